/* design/rct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RNA codon translator package
// Base codes, the standard genetic code table and the lookup helpers.
// ----------------------------------------------------------------------------
package rct_pkg;

    typedef logic [7:0] char_t;
    typedef logic [2:0] base_code_t;
    typedef logic [1:0] codon_pos_t;
    typedef logic [5:0] codon_idx_t;

    localparam base_code_t BASE_A   = 3'd0;
    localparam base_code_t BASE_C   = 3'd1;
    localparam base_code_t BASE_G   = 3'd2;
    localparam base_code_t BASE_U   = 3'd3;
    localparam base_code_t BASE_BAD = 3'd4;

    localparam codon_pos_t POS_FIRST  = 2'd0;
    localparam codon_pos_t POS_SECOND = 2'd1;
    localparam codon_pos_t POS_THIRD  = 2'd2;

    localparam char_t STOP_CHAR = 8'h2A;
    localparam char_t NO_CHAR   = 8'h00;

    // Index is first*16 + second*4 + third with base order A, C, G, U.
    localparam logic [511:0] CODE_TABLE = {
        "KNKNTTTTRSRSIIMI",
        "QHQHPPPPRRRRLLLL",
        "EDEDAAAAGGGGVVVV",
        "*Y*YSSSS*CWCLFLF"
    };

    function automatic base_code_t base_code(input char_t ch);
        base_code_t code;
        case (ch)
            "A":     code = BASE_A;
            "C":     code = BASE_C;
            "G":     code = BASE_G;
            "U":     code = BASE_U;
            default: code = BASE_BAD;
        endcase
        return code;
    endfunction

    function automatic char_t codon_lookup(input codon_idx_t idx);
        logic [8:0] bit_pos;
        bit_pos = {(6'd63 - idx), 3'b000};
        return CODE_TABLE[bit_pos +: 8];
    endfunction

endpackage

/* design/rna_codon_translator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RNA codon translator core
// Groups an ASCII RNA stream into codons and emits one-letter amino acids.
// ----------------------------------------------------------------------------
// One nucleotide is taken per cycle while the result register is free or being
// read. Each transaction passes an input register and then a result register.
// A stop codon silences the stream until the transaction marked last, which
// always produces exactly one result with end_of_protein set; the codon state
// then returns to its reset value.
module rna_codon_translator_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rct_pkg::char_t   s_nucleotide,
    input  logic             s_last,
    output logic             m_valid,
    input  logic             m_ready,
    output rct_pkg::char_t   m_amino_acid,
    output logic             m_acid_valid,
    output logic             m_end_of_protein
);
    import rct_pkg::*;

    logic       in_valid_reg;
    char_t      in_nucleotide_reg;
    logic       in_last_reg;

    codon_pos_t pos_reg, pos_next;
    base_code_t first_reg, first_next;
    base_code_t second_reg, second_next;
    logic       stopped_reg, stopped_next;

    logic       out_valid_reg, out_valid_next;
    char_t      out_acid_reg, out_acid_next;
    logic       out_acid_valid_reg, out_acid_valid_next;
    logic       out_end_reg, out_end_next;

    logic       out_free;
    logic       advance;
    base_code_t code;
    char_t      acid;
    logic       have_acid;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign code = base_code(in_nucleotide_reg);
    assign acid = codon_lookup({first_reg[1:0], second_reg[1:0], code[1:0]});

    always_comb begin
        pos_next            = pos_reg;
        first_next          = first_reg;
        second_next         = second_reg;
        stopped_next        = stopped_reg;
        have_acid           = 1'b0;
        out_valid_next      = out_valid_reg && !m_ready;
        out_acid_next       = out_acid_reg;
        out_acid_valid_next = out_acid_valid_reg;
        out_end_next        = out_end_reg;
        if (advance) begin
            if (!stopped_reg) begin
                case (pos_reg)
                    POS_FIRST: begin
                        first_next = code;
                        pos_next   = POS_SECOND;
                    end
                    POS_SECOND: begin
                        second_next = code;
                        pos_next    = POS_THIRD;
                    end
                    default: begin
                        pos_next = POS_FIRST;
                        if (first_reg != BASE_BAD && second_reg != BASE_BAD &&
                            code != BASE_BAD) begin
                            if (acid == STOP_CHAR) begin
                                stopped_next = 1'b1;
                            end else begin
                                have_acid = 1'b1;
                            end
                        end
                    end
                endcase
            end
            if (in_last_reg || have_acid) begin
                out_valid_next      = 1'b1;
                out_acid_next       = have_acid ? acid : NO_CHAR;
                out_acid_valid_next = have_acid;
                out_end_next        = in_last_reg;
            end
            if (in_last_reg) begin
                pos_next     = POS_FIRST;
                first_next   = BASE_A;
                second_next  = BASE_A;
                stopped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= POS_FIRST;
            first_reg     <= BASE_A;
            second_reg    <= BASE_A;
            stopped_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            stopped_reg   <= stopped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_nucleotide_reg <= s_nucleotide;
            in_last_reg       <= s_last;
        end
        out_acid_reg       <= out_acid_next;
        out_acid_valid_reg <= out_acid_valid_next;
        out_end_reg        <= out_end_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_amino_acid     = out_acid_reg;
    assign m_acid_valid     = out_acid_valid_reg;
    assign m_end_of_protein = out_end_reg;

endmodule
